// ===== hw/rtl/can_frame_change_tracker_core_macros.svh =====
// Assertion macros for the CAN frame change tracker checker.
// Used by cfct_checker only; no other dependencies.
`ifndef CAN_FRAME_CHANGE_TRACKER_CORE_MACROS_SVH
`define CAN_FRAME_CHANGE_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, masked during reset
`define CFCT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfct check failed");

// Next-cycle implication, masked during reset
`define CFCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfct check failed");

// Next-cycle implication, checked also while reset is high
`define CFCT_ASSERT_NEXT_ANY(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cfct check failed");

`endif

// ===== hw/rtl/cfct_pkg.sv =====
// Shared types and constants for the CAN frame change tracker.
// No dependencies.
package cfct_pkg;

   localparam int Entries = 32;
   localparam int IdxW    = $clog2(Entries);
   localparam int FillW   = $clog2(Entries + 1);
   localparam int MaxOut  = 32;
   localparam int PortW   = 2;
   localparam int IdW     = 29;
   localparam int LenW    = 4;
   localparam int DataW   = 64;
   localparam int CountW  = 14;
   localparam int SlotW   = 5;
   localparam int StatusW = 3;

   localparam logic [CountW-1:0] CountMax = CountW'(10000);
   localparam logic [LenW-1:0]   MaxLen   = LenW'(8);

   typedef enum logic [StatusW-1:0] {
      ST_NEW        = 3'd0,
      ST_CHANGED    = 3'd1,
      ST_UNCHANGED  = 3'd2,
      ST_FULL       = 3'd3,
      ST_DUMP_ENTRY = 3'd4,
      ST_DUMP_EMPTY = 3'd5
   } status_type;

   typedef struct packed {
      logic [IdW-1:0]    id;
      logic [PortW-1:0]  port;
      logic              ext;
      logic              rtr;
      logic [LenW-1:0]   len;
      logic [DataW-1:0]  payload;
      logic [CountW-1:0] count;
   } entry_type;

   typedef struct packed {
      status_type        status;
      logic [SlotW-1:0]  slot;
      entry_type         entry;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              frame_load;
      logic [IdxW-1:0]   rd_addr;
      logic              wr_en;
      logic              wr_new;
      logic [IdxW-1:0]   wr_addr;
      logic              out_load;
      status_type        out_status;
      logic              out_last;
      logic              out_zero;
   } dp_cmd_type;

   typedef struct packed {
      logic is_dump;
      logic id_hit;
      logic data_diff;
      logic count_nz;
   } dp_stat_type;

endpackage

// ===== hw/rtl/cfct_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on cfct_pkg for field widths.
interface cfct_req_if;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [cfct_pkg::PortW-1:0]   port;
   logic [cfct_pkg::IdW-1:0]     frame_id;
   logic                         is_extended;
   logic                         remote;
   logic [cfct_pkg::LenW-1:0]    length;
   logic [cfct_pkg::DataW-1:0]   payload;

   modport source (output valid, operation, port, frame_id, is_extended, remote,
                   length, payload, input ready);
   modport sink   (input valid, operation, port, frame_id, is_extended, remote,
                   length, payload, output ready);
endinterface

interface cfct_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cfct_pkg::StatusW-1:0] status;
   logic [cfct_pkg::SlotW-1:0]   slot;
   logic [cfct_pkg::PortW-1:0]   entry_port;
   logic [cfct_pkg::IdW-1:0]     entry_id;
   logic                         entry_extended;
   logic                         entry_remote;
   logic [cfct_pkg::LenW-1:0]    entry_length;
   logic [cfct_pkg::DataW-1:0]   entry_payload;
   logic [cfct_pkg::CountW-1:0]  change_count;
   logic                         last;

   modport source (output valid, status, slot, entry_port, entry_id, entry_extended,
                   entry_remote, entry_length, entry_payload, change_count, last,
                   input ready);
   modport sink   (input valid, status, slot, entry_port, entry_id, entry_extended,
                   entry_remote, entry_length, entry_payload, change_count, last,
                   output ready);
endinterface

// ===== hw/rtl/can_frame_change_tracker_core.sv =====
// Frame: the table is searched slot by slot, up to the fill count, then one result is issued.
// Dump: one result per slot with a nonzero change count, plus stalls on the response side.
// Scan rate is set by the single read port of the entry memory: each slot is read, then checked.
// A new word is accepted once the previous one has issued its final result.
// Synchronous reset empties the table by clearing the fill count; no sweep needed.
module can_frame_change_tracker_core (
   input logic       clock,
   input logic       reset,
   cfct_req_if.sink  req_chan,
   cfct_rsp_if.source rsp_chan
);

   cfct_pkg::dp_cmd_type   cmd;
   cfct_pkg::dp_stat_type  stat;
   cfct_pkg::rsp_type      rsp_word;

   cfct_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   cfct_dp u_dp (
      .clock           (clock),
      .req_operation   (req_chan.operation),
      .req_port        (req_chan.port),
      .req_frame_id    (req_chan.frame_id),
      .req_is_extended (req_chan.is_extended),
      .req_remote      (req_chan.remote),
      .req_length      (req_chan.length),
      .req_payload     (req_chan.payload),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_word        (rsp_word)
   );

   assign rsp_chan.status         = rsp_word.status;
   assign rsp_chan.slot           = rsp_word.slot;
   assign rsp_chan.entry_port     = rsp_word.entry.port;
   assign rsp_chan.entry_id       = rsp_word.entry.id;
   assign rsp_chan.entry_extended = rsp_word.entry.ext;
   assign rsp_chan.entry_remote   = rsp_word.entry.rtr;
   assign rsp_chan.entry_length   = rsp_word.entry.len;
   assign rsp_chan.entry_payload  = rsp_word.entry.payload;
   assign rsp_chan.change_count   = rsp_word.entry.count;
   assign rsp_chan.last           = rsp_word.last;

endmodule

// ===== hw/rtl/cfct_dp.sv =====
// Datapath of the CAN frame change tracker: frame register, entry memory,
// compare and merge logic, response register. Depends on cfct_pkg.
module cfct_dp (
   input  logic                          clock,
   input  logic                          req_operation,
   input  logic [cfct_pkg::PortW-1:0]    req_port,
   input  logic [cfct_pkg::IdW-1:0]      req_frame_id,
   input  logic                          req_is_extended,
   input  logic                          req_remote,
   input  logic [cfct_pkg::LenW-1:0]     req_length,
   input  logic [cfct_pkg::DataW-1:0]    req_payload,
   input  cfct_pkg::dp_cmd_type          cmd,
   output cfct_pkg::dp_stat_type         stat,
   output cfct_pkg::rsp_type             rsp_word
);

   typedef struct packed {
      logic                         op;
      logic [cfct_pkg::PortW-1:0]   port;
      logic [cfct_pkg::IdW-1:0]     id;
      logic                         ext;
      logic                         rtr;
      logic [cfct_pkg::LenW-1:0]    len;
      logic [cfct_pkg::DataW-1:0]   data;
      logic [cfct_pkg::DataW-1:0]   mask;
   } frame_type;

   frame_type            frame_ff;
   frame_type            frame_in;
   cfct_pkg::entry_type  entry_mem [cfct_pkg::Entries];
   cfct_pkg::entry_type  rd_ff;
   cfct_pkg::entry_type  wr_data;
   cfct_pkg::entry_type  new_entry;
   cfct_pkg::entry_type  upd_entry;
   cfct_pkg::rsp_type    out_ff;
   cfct_pkg::rsp_type    out_in;

   // clamp length to eight bytes and build the byte enable mask
   always_comb begin
      frame_in.op   = req_operation;
      frame_in.port = req_port;
      frame_in.id   = req_frame_id;
      frame_in.ext  = req_is_extended;
      frame_in.rtr  = req_remote;
      frame_in.len  = (req_length > cfct_pkg::MaxLen) ? cfct_pkg::MaxLen : req_length;
      frame_in.data = req_payload;
      for (int b = 0; b < 8; b++) begin
         frame_in.mask[8*b +: 8] = {8{frame_in.len > cfct_pkg::LenW'(b)}};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.frame_load) begin
         frame_ff <= frame_in;
      end
   end

   always_comb begin
      new_entry.id      = frame_ff.id;
      new_entry.port    = frame_ff.port;
      new_entry.ext     = frame_ff.ext;
      new_entry.rtr     = frame_ff.rtr;
      new_entry.len     = frame_ff.len;
      new_entry.payload = frame_ff.data & frame_ff.mask;
      new_entry.count   = '0;

      upd_entry.id      = rd_ff.id;
      upd_entry.port    = frame_ff.port;
      upd_entry.ext     = frame_ff.ext;
      upd_entry.rtr     = frame_ff.rtr;
      upd_entry.len     = frame_ff.len;
      // copy only the bytes covered by the length
      upd_entry.payload = (rd_ff.payload & ~frame_ff.mask) | (frame_ff.data & frame_ff.mask);
      upd_entry.count   = (rd_ff.count < cfct_pkg::CountMax) ?
                          rd_ff.count + cfct_pkg::CountW'(1) : rd_ff.count;

      wr_data = cmd.wr_new ? new_entry : upd_entry;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entry_mem[cmd.wr_addr] <= wr_data;
      end
      rd_ff <= entry_mem[cmd.rd_addr];
   end

   always_comb begin
      stat.is_dump   = frame_ff.op;
      stat.id_hit    = (rd_ff.id == frame_ff.id);
      stat.data_diff = |((rd_ff.payload ^ frame_ff.data) & frame_ff.mask);
      stat.count_nz  = |rd_ff.count;
   end

   always_comb begin
      out_in.status = cmd.out_status;
      out_in.last   = cmd.out_last;
      if (cmd.out_zero) begin
         out_in.slot  = '0;
         out_in.entry = '0;
      end else if (cmd.wr_en) begin
         out_in.slot  = cfct_pkg::SlotW'(cmd.wr_addr);
         out_in.entry = wr_data;
      end else begin
         out_in.slot  = cfct_pkg::SlotW'(cmd.rd_addr);
         out_in.entry = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_word = out_ff;

endmodule

// ===== hw/rtl/cfct_ctrl.sv =====
// Controller of the CAN frame change tracker: search and dump sequencer,
// fill and change bookkeeping, handshakes. Depends on cfct_pkg.
module cfct_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_operation,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  cfct_pkg::dp_stat_type  stat,
   output cfct_pkg::dp_cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_FRAME_OUT,
      S_NEW_OUT,
      S_EMPTY_OUT
   } state_type;

   state_type                      state_ff, state_in;
   logic [cfct_pkg::IdxW-1:0]      idx_ff, idx_in;
   logic [cfct_pkg::FillW-1:0]     fill_ff, fill_in;
   logic [cfct_pkg::FillW-1:0]     nz_ff, nz_in;
   logic [cfct_pkg::FillW-1:0]     sent_ff, sent_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           out_free;
   logic                           dump_last;
   logic                           scan_end;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign dump_last = (cfct_pkg::FillW'(sent_ff + 1'b1) == nz_ff) ||
                      (cfct_pkg::FillW'(sent_ff + 1'b1) == cfct_pkg::FillW'(cfct_pkg::MaxOut));
   assign scan_end  = (cfct_pkg::FillW'(idx_ff) + 1'b1) == fill_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      nz_in        = nz_ff;
      sent_in      = sent_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.rd_addr  = idx_ff;
      cmd.wr_addr  = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.frame_load = 1'b1;
               idx_in         = '0;
               sent_in        = '0;
               if (req_operation) begin
                  state_in = (nz_ff == '0) ? S_EMPTY_OUT : S_READ;
               end else begin
                  state_in = (fill_ff == '0) ? S_NEW_OUT : S_READ;
               end
            end
         end

         S_READ: begin
            state_in = S_CHECK;
         end

         S_CHECK: begin
            if (stat.is_dump) begin
               if (!stat.count_nz) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end else if (out_free) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_status = cfct_pkg::ST_DUMP_ENTRY;
                  cmd.out_last   = dump_last;
                  rsp_valid_in   = 1'b1;
                  sent_in        = sent_ff + 1'b1;
                  if (dump_last) begin
                     // report done: empty the table
                     fill_in  = '0;
                     nz_in    = '0;
                     state_in = S_IDLE;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_READ;
                  end
               end
            end else if (stat.id_hit) begin
               state_in = S_FRAME_OUT;
            end else if (scan_end) begin
               state_in = S_NEW_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end

         S_FRAME_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (stat.data_diff) begin
                  cmd.wr_en      = 1'b1;
                  cmd.out_status = cfct_pkg::ST_CHANGED;
                  if (!stat.count_nz) begin
                     nz_in = nz_ff + 1'b1;
                  end
               end else begin
                  cmd.out_status = cfct_pkg::ST_UNCHANGED;
               end
            end
         end

         S_NEW_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (fill_ff < cfct_pkg::FillW'(cfct_pkg::Entries)) begin
                  cmd.wr_en      = 1'b1;
                  cmd.wr_new     = 1'b1;
                  cmd.wr_addr    = fill_ff[cfct_pkg::IdxW-1:0];
                  cmd.out_status = cfct_pkg::ST_NEW;
                  fill_in        = fill_ff + 1'b1;
               end else begin
                  cmd.out_zero   = 1'b1;
                  cmd.out_status = cfct_pkg::ST_FULL;
               end
            end
         end

         S_EMPTY_OUT: begin
            if (out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_zero   = 1'b1;
               cmd.out_last   = 1'b1;
               cmd.out_status = cfct_pkg::ST_DUMP_EMPTY;
               rsp_valid_in   = 1'b1;
               fill_in        = '0;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         fill_ff      <= '0;
         nz_ff        <= '0;
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         fill_ff      <= fill_in;
         nz_ff        <= nz_in;
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/cfct_checker.sv =====
// Port-level checks for the CAN frame change tracker, bound to the top level.
// Depends on cfct_pkg and can_frame_change_tracker_core_macros.svh.
`include "can_frame_change_tracker_core_macros.svh"

module cfct_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cfct_pkg::StatusW-1:0]  rsp_status,
   input logic [cfct_pkg::SlotW-1:0]    rsp_slot,
   input logic [cfct_pkg::CountW-1:0]   rsp_change_count,
   input logic                          rsp_last
);

   // hold a stalled response word
   `CFCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_last))

   // one word in flight: no accept right after an accept
   `CFCT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   `CFCT_ASSERT_SAME(a_empty_fields, clock, reset, rsp_valid && (rsp_status == cfct_pkg::ST_DUMP_EMPTY), rsp_last && (rsp_slot == '0) && (rsp_change_count == '0))

   `CFCT_ASSERT_SAME(a_full_fields, clock, reset, rsp_valid && (rsp_status == cfct_pkg::ST_FULL), rsp_last && (rsp_slot == '0) && (rsp_change_count == '0))

   `CFCT_ASSERT_NEXT_ANY(a_reset_idle, clock, reset, !rsp_valid && req_ready)

endmodule

bind can_frame_change_tracker_core cfct_checker u_cfct_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_slot         (rsp_chan.slot),
   .rsp_change_count (rsp_chan.change_count),
   .rsp_last         (rsp_chan.last)
);

// ===== tb/sv/cfct_tb_pkg.sv =====
// Operation codes shared by the change tracker bench files.
// No dependencies; compiled before cfct_checker and tb_top.
`timescale 1ns / 1ps
package cfct_tb_pkg;

   typedef enum logic {
      OP_FRAME = 1'b0,
      OP_DUMP  = 1'b1
   } op_type;

endpackage

// ===== tb/sv/cfct_checker.sv =====
// Scoreboard for the CAN frame change tracker: shadows the frame table,
// predicts each result word and compares it on the response channel.
// Depends on cfct_pkg, cfct_tb_pkg and the channel interfaces in cfct_if.
`timescale 1ns / 1ps
module cfct_scoreboard
   import cfct_pkg::*;
   import cfct_tb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   cfct_req_if  req_mon,
   cfct_rsp_if  rsp_mon,
   output int   mismatches,
   output int   due_count,
   output int   reports_seen,
   output int   full_seen,
   output int   dump_entries_seen
);

   entry_type table_copy [Entries];
   int        table_fill;
   rsp_type   due_reports [$];
   rsp_type   oldest;

   function automatic void clear_table_copy();
      table_fill = 0;
      for (int i = 0; i < Entries; i++) table_copy[i] = '0;
   endfunction

   function automatic void track_frame(input logic [PortW-1:0] port,
                                       input logic [IdW-1:0] id,
                                       input logic ext,
                                       input logic rtr,
                                       input logic [LenW-1:0] length,
                                       input logic [DataW-1:0] data);
      rsp_type          rpt;
      logic [LenW-1:0]  len_used;
      logic [DataW-1:0] keep;
      int               hit;
      rpt      = '0;
      rpt.last = 1'b1;
      len_used = (length > MaxLen) ? MaxLen : length;
      keep     = {DataW{1'b1}} >> (8 * (MaxLen - len_used));
      hit      = -1;
      // match on identifier only; port and format flag play no part
      for (int i = 0; i < table_fill; i++)
         if (hit < 0 && table_copy[i].id == id) hit = i;
      if (hit >= 0) begin
         if (((table_copy[hit].payload ^ data) & keep) != '0) begin
            table_copy[hit].port    = port;
            table_copy[hit].ext     = ext;
            table_copy[hit].rtr     = rtr;
            table_copy[hit].len     = len_used;
            table_copy[hit].payload = (table_copy[hit].payload & ~keep) | (data & keep);
            if (table_copy[hit].count < CountMax)
               table_copy[hit].count = table_copy[hit].count + 1'b1;
            rpt.status = ST_CHANGED;
         end else begin
            rpt.status = ST_UNCHANGED;
         end
         rpt.slot  = SlotW'(hit);
         rpt.entry = table_copy[hit];
      end else if (table_fill < Entries) begin
         table_copy[table_fill] = '{id: id, port: port, ext: ext, rtr: rtr, len: len_used,
                                    payload: data & keep, count: '0};
         rpt.status = ST_NEW;
         rpt.slot   = SlotW'(table_fill);
         rpt.entry  = table_copy[table_fill];
         table_fill++;
      end else begin
         rpt.status = ST_FULL;
      end
      due_reports.push_back(rpt);
   endfunction

   function automatic void track_dump();
      rsp_type rpt;
      int      total;
      int      sent;
      total = 0;
      sent  = 0;
      for (int i = 0; i < table_fill; i++)
         if (table_copy[i].count != '0) total++;
      if (total > MaxOut) total = MaxOut;
      for (int i = 0; i < table_fill; i++) begin
         if (table_copy[i].count != '0 && sent < total) begin
            rpt        = '0;
            rpt.status = ST_DUMP_ENTRY;
            rpt.slot   = SlotW'(i);
            rpt.entry  = table_copy[i];
            rpt.last   = (sent == total - 1);
            due_reports.push_back(rpt);
            sent++;
         end
      end
      if (total == 0) begin
         rpt        = '0;
         rpt.status = ST_DUMP_EMPTY;
         rpt.last   = 1'b1;
         due_reports.push_back(rpt);
      end
      clear_table_copy();
   endfunction

   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_table_copy();
         due_reports.delete();
         mismatches        = 0;
         reports_seen      = 0;
         full_seen         = 0;
         dump_entries_seen = 0;
      end else begin
         // take the request first: its results can never leave on the same edge
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.operation == OP_DUMP)
               track_dump();
            else
               track_frame(req_mon.port, req_mon.frame_id, req_mon.is_extended,
                           req_mon.remote, req_mon.length, req_mon.payload);
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (due_reports.size() == 0) begin
               $error("result word with nothing due: status %0d slot %0d",
                      rsp_mon.status, rsp_mon.slot);
               mismatches++;
            end else begin
               oldest = due_reports.pop_front();
               check_field("status", 64'(oldest.status), 64'(rsp_mon.status));
               check_field("slot", 64'(oldest.slot), 64'(rsp_mon.slot));
               check_field("entry_port", 64'(oldest.entry.port), 64'(rsp_mon.entry_port));
               check_field("entry_id", 64'(oldest.entry.id), 64'(rsp_mon.entry_id));
               check_field("entry_extended", 64'(oldest.entry.ext),
                           64'(rsp_mon.entry_extended));
               check_field("entry_remote", 64'(oldest.entry.rtr), 64'(rsp_mon.entry_remote));
               check_field("entry_length", 64'(oldest.entry.len), 64'(rsp_mon.entry_length));
               check_field("entry_payload", oldest.entry.payload, rsp_mon.entry_payload);
               check_field("change_count", 64'(oldest.entry.count),
                           64'(rsp_mon.change_count));
               check_field("last", 64'(oldest.last), 64'(rsp_mon.last));
               reports_seen++;
               if (oldest.status == ST_FULL) full_seen++;
               if (oldest.status == ST_DUMP_ENTRY) dump_entries_seen++;
            end
         end
      end
      due_count = due_reports.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the change tracker bench: clock, reset, frame and dump stimulus,
// response back-pressure and the verdict. Depends on cfct_pkg, cfct_tb_pkg,
// cfct_if, cfct_scoreboard and can_frame_change_tracker_core.
`timescale 1ns / 1ps
module tb_top;
   import cfct_pkg::*;
   import cfct_tb_pkg::*;

   localparam int HoldOffCycles = 300;
   localparam int SettleCycles  = 80;
   localparam int ItemTarget    = 230;
   localparam int TailFrames    = 8;
   localparam int TailItems     = TailFrames + 3;

   logic clock = 1'b0;
   logic reset;
   bit   idle_on;
   bit   hold_off_wanted;
   int   frames_sent;
   int   dumps_sent;
   int   mismatches;
   int   due_count;
   int   reports_seen;
   int   full_seen;
   int   dump_entries_seen;

   logic [IdW-1:0]   id_pool [$];
   logic [DataW-1:0] data_pool [$];

   cfct_req_if req_bus ();
   cfct_rsp_if rsp_bus ();

   can_frame_change_tracker_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   cfct_scoreboard u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_bus),
      .rsp_mon           (rsp_bus),
      .mismatches        (mismatches),
      .due_count         (due_count),
      .reports_seen      (reports_seen),
      .full_seen         (full_seen),
      .dump_entries_seen (dump_entries_seen)
   );

   always #2 clock = ~clock;

   // Offer one word at a falling edge and return at the edge that takes it.
   task automatic send_word(input op_type op, input logic [PortW-1:0] port,
                            input logic [IdW-1:0] id, input logic ext, input logic rtr,
                            input logic [LenW-1:0] length, input logic [DataW-1:0] data);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= op;
      req_bus.port        <= port;
      req_bus.frame_id    <= id;
      req_bus.is_extended <= ext;
      req_bus.remote      <= rtr;
      req_bus.length      <= length;
      req_bus.payload     <= data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (op == OP_DUMP) dumps_sent++;
      else frames_sent++;
   endtask

   task automatic send_dump();
      // frame fields are ignored on a dump: fill them with noise
      send_word(OP_DUMP, PortW'($urandom), IdW'($urandom), 1'($urandom), 1'($urandom),
                LenW'($urandom), {$urandom, $urandom});
   endtask

   function automatic logic [LenW-1:0] pick_length();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 10) return MaxLen;
      if (pick < 17) return LenW'($urandom_range(1, 7));
      return LenW'($urandom_range(0, 15));
   endfunction

   function automatic logic [PortW-1:0] pick_port();
      if ($urandom_range(0, 9) == 0) return PortW'($urandom_range(0, 3));
      return PortW'($urandom_range(1, 2));
   endfunction

   function automatic logic [IdW-1:0] pick_id();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return IdW'($urandom_range(0, 2047));
         default: return IdW'($urandom);
      endcase
   endfunction

   function automatic void fill_pool(input int size);
      logic [IdW-1:0] id;
      bit             dup;
      id_pool.delete();
      data_pool.delete();
      while (id_pool.size() < size) begin
         id  = pick_id();
         dup = 1'b0;
         foreach (id_pool[j]) if (id_pool[j] == id) dup = 1'b1;
         if (!dup) begin
            id_pool.push_back(id);
            data_pool.push_back({$urandom, $urandom});
         end
      end
   endfunction

   // Resend, nudge one byte of, or replace the last payload of a pooled ID.
   task automatic send_pool_frame();
      int               k;
      int               pick;
      logic [DataW-1:0] data;
      k    = $urandom_range(0, id_pool.size() - 1);
      data = data_pool[k];
      pick = $urandom_range(0, 9);
      if (pick >= 8)
         data = {$urandom, $urandom};
      else if (pick >= 4)
         data = data ^ (DataW'($urandom_range(1, 255)) << (8 * $urandom_range(0, 7)));
      data_pool[k] = data;
      send_word(OP_FRAME, pick_port(), id_pool[k], 1'($urandom), 1'($urandom),
                pick_length(), data);
   endtask

   // Response side: random ready bursts plus one long hold-off.
   initial begin
      int span;
      bit held;
      rsp_bus.ready = 1'b0;
      held          = 1'b0;
      @(negedge clock iff !reset);
      forever begin
         if (hold_off_wanted && !held) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            span = HoldOffCycles;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            span = $urandom_range(1, 13);
         end else begin
            rsp_bus.ready <= 1'b1;
            span = $urandom_range(1, 24);
         end
         repeat (span) @(negedge clock);
      end
   end

   initial begin
      int               pick;
      bit               flip;
      logic [IdW-1:0]   tail_id;
      req_bus.valid       = 1'b0;
      req_bus.operation   = OP_FRAME;
      req_bus.port        = '0;
      req_bus.frame_id    = '0;
      req_bus.is_extended = 1'b0;
      req_bus.remote      = 1'b0;
      req_bus.length      = '0;
      req_bus.payload     = '0;
      reset           = 1'b1;
      idle_on         = 1'b1;
      hold_off_wanted = 1'b0;
      frames_sent     = 0;
      dumps_sent      = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed: empty dump, zero length, extremes of ID and length, odd ports
      send_dump();
      send_word(OP_FRAME, 2'd1, '0, 1'b0, 1'b0, 4'd0, '1);
      send_word(OP_FRAME, 2'd1, '0, 1'b0, 1'b0, 4'd0, 64'h5);
      send_word(OP_FRAME, 2'd2, '1, 1'b1, 1'b1, 4'd8, '1);
      send_word(OP_FRAME, 2'd2, '1, 1'b1, 1'b0, 4'd15, '0);
      send_word(OP_FRAME, 2'd3, '1, 1'b0, 1'b1, 4'd1, 64'hFF);
      send_word(OP_FRAME, 2'd0, '1, 1'b1, 1'b0, 4'd1, '1);
      // same ID under another port and format still hits the entry
      send_word(OP_FRAME, 2'd2, '0, 1'b1, 1'b1, 4'd4, 64'h0123_4567_89AB_CDEF);
      send_word(OP_FRAME, 2'd1, 29'h7FF, 1'b0, 1'b0, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA);
      send_word(OP_FRAME, 2'd1, 29'h7FF, 1'b0, 1'b0, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA);
      send_word(OP_FRAME, 2'd2, 29'h1, 1'b1, 1'b0, 4'd9, 64'h5555_5555_5555_5555);
      send_word(OP_FRAME, 2'd1, '1, 1'b1, 1'b0, 4'd7, {$urandom, $urandom});
      send_dump();
      send_dump();
      send_word(OP_FRAME, 2'd2, '0, 1'b0, 1'b0, 4'd8, 64'hDEAD_BEEF_0000_1111);
      send_word(OP_FRAME, 2'd1, '0, 1'b0, 1'b1, 4'd2, 64'hFFFF_FFFF_FFFF_0000);
      send_dump();

      hold_off_wanted = 1'b1;

      // fill every slot, overflow, then change every entry and dump a full table
      fill_pool(Entries + 2);
      foreach (id_pool[k])
         send_word(OP_FRAME, pick_port(), id_pool[k], 1'($urandom), 1'($urandom),
                   MaxLen, data_pool[k]);
      for (int k = id_pool.size() - 1; k >= 0; k--)
         send_word(OP_FRAME, pick_port(), id_pool[k], 1'($urandom), 1'($urandom),
                   LenW'($urandom_range(1, 8)),
                   data_pool[k] ^ DataW'($urandom_range(1, 255)));
      send_dump();

      while (frames_sent + dumps_sent < ItemTarget - TailItems) begin
         fill_pool(($urandom_range(0, 5) == 0) ? $urandom_range(28, 40)
                                               : $urandom_range(1, 12));
         repeat ($urandom_range(4, 30)) begin
            if (frames_sent + dumps_sent >= ItemTarget - TailItems) break;
            pick = $urandom_range(0, 19);
            if (pick == 0)
               send_dump();
            else if (pick == 1)
               send_word(OP_FRAME, pick_port(), pick_id(), 1'($urandom), 1'($urandom),
                         pick_length(), {$urandom, $urandom});
            else
               send_pool_frame();
         end
         send_dump();
      end

      // no idling from here: toggle one ID's payload so every repeat after its first frame counts a change
      idle_on = 1'b0;
      tail_id = IdW'($urandom);
      flip    = 1'b0;
      send_dump();
      repeat (TailFrames) begin
         flip = ~flip;
         send_word(OP_FRAME, 2'd1, tail_id, 1'b1, 1'b0, MaxLen, flip ? '1 : '0);
      end
      send_word(OP_FRAME, 2'd2, tail_id, 1'b1, 1'b0, MaxLen, flip ? '1 : '0);
      send_dump();

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
      $display("Run covered %0d frames and %0d dumps; %0d result words checked.",
               frames_sent, dumps_sent, reports_seen);
      $display("Table-full results: %0d; dump entries: %0d; one ID changed back to back.",
               full_seen, dump_entries_seen);
      if (mismatches == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      #4000000;
      $display("Timeout with %0d result words still due.", due_count);
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
